>>> hw/rtl/voronoi_nearest_seed_edge_assert.svh
// Assertion macros shared by the nearest-seed block.
// Needs signals clk and arst_n in the module that uses them.
`ifndef VORONOI_NEAREST_SEED_EDGE_ASSERT_SVH
`define VORONOI_NEAREST_SEED_EDGE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define VNS_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Condition implies consequence in the following cycle.
`define VNS_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

>>> hw/rtl/vns_pkg.sv
// Types, constants and codes of the nearest-seed block.
// No dependencies.
package vns_pkg;

	localparam int SEED_SLOTS   = 64;
	localparam int GRID_COLUMNS = 128;
	localparam int GRID_ROWS    = 32;

	localparam int IDX_W  = 6;
	localparam int X_W    = 15;
	localparam int Y_W    = 13;
	localparam int R_W    = 16;
	localparam int CX_W   = 7;
	localparam int CY_W   = 5;
	localparam int EW_W   = 12;
	localparam int ENT_W  = X_W + Y_W + R_W;
	localparam int DX2_W  = 2 * X_W;
	localparam int DY2_W  = 2 * Y_W;
	localparam int D_W    = DX2_W + 1;
	localparam int R2_W   = 2 * R_W;
	localparam int RAD_W  = 32;
	localparam int ROOT_W = RAD_W / 2;
	localparam int NUM_W  = ROOT_W + 9;
	localparam int EDGE_W = 9;

	localparam logic [EW_W-1:0] EDGE_WIDTH_RESET = 12'd384;
	localparam logic [CX_W-1:0] CX_MAX = CX_W'(GRID_COLUMNS - 1);
	localparam logic [CY_W-1:0] CY_MAX = CY_W'(GRID_ROWS - 1);

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic              action;
		logic [IDX_W-1:0]  seed_index;
		logic [X_W-1:0]    seed_x;
		logic [Y_W-1:0]    seed_y;
		logic [R_W-1:0]    seed_radius;
		logic              seed_active;
		logic [CX_W-1:0]   cell_x;
		logic [CY_W-1:0]   cell_y;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  owner;
		logic              covered;
		logic [R_W-1:0]    nearest_distance;
		logic [EDGE_W-1:0] edge_proximity;
	} out_item_t;

	typedef struct packed {
		logic             write;
		logic             start_query;
		logic             scan_valid;
		logic [IDX_W-1:0] scan_addr;
		logic             sqrt_go;
		logic             sqrt_sel;
		logic             div_go;
		logic             load_out;
	} cmd_t;

	typedef struct packed {
		logic       scan_busy;
		logic [1:0] hits;
		logic       sqrt_busy;
		logic       div_busy;
	} stat_t;

endpackage

>>> hw/rtl/vns_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on vns_pkg.
module vns_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [vns_pkg::RAD_W-1:0]  radicand,
	output logic                       busy,
	output logic                       done,
	output logic [vns_pkg::ROOT_W-1:0] root
);

	logic                       busy_q;
	logic                       done_q;
	logic [3:0]                 cnt_q;
	logic [vns_pkg::RAD_W-1:0]  val_q;
	logic [vns_pkg::ROOT_W+1:0] rem_q;
	logic [vns_pkg::ROOT_W-1:0] root_q;
	logic [vns_pkg::ROOT_W+3:0] rem_n;
	logic [vns_pkg::ROOT_W+3:0] trial;

	// Bring down two radicand bits and try the next root bit
	assign rem_n = {rem_q, val_q[vns_pkg::RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};

	// Control: count sixteen steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: restoring square root step
	always_ff @(posedge clk) begin
		if (go) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[vns_pkg::RAD_W-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= (vns_pkg::ROOT_W+2)'(rem_n - trial);
				root_q <= {root_q[vns_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= (vns_pkg::ROOT_W+2)'(rem_n);
				root_q <= {root_q[vns_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

>>> hw/rtl/vns_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on vns_pkg.
module vns_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [vns_pkg::NUM_W-1:0] num,
	input  logic [vns_pkg::EW_W-1:0]  den,
	output logic                      busy,
	output logic [vns_pkg::NUM_W-1:0] quo
);

	logic                      busy_q;
	logic [4:0]                cnt_q;
	logic [vns_pkg::NUM_W-1:0] num_q;
	logic [vns_pkg::NUM_W-1:0] quo_q;
	logic [vns_pkg::EW_W-1:0]  den_q;
	logic [vns_pkg::EW_W-1:0]  rem_q;
	logic [vns_pkg::EW_W:0]    rem_n;

	assign rem_n = {rem_q, num_q[vns_pkg::NUM_W-1]};

	// Control: count one step per numerator bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(vns_pkg::NUM_W - 1))
				busy_q <= 1'b0;
		end
	end

	// Datapath: shift, compare, subtract
	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[vns_pkg::NUM_W-2:0], 1'b0};
			if (rem_n >= {1'b0, den_q}) begin
				rem_q <= vns_pkg::EW_W'(rem_n - {1'b0, den_q});
				quo_q <= {quo_q[vns_pkg::NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= vns_pkg::EW_W'(rem_n);
				quo_q <= {quo_q[vns_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

>>> hw/rtl/vns_datapath.sv
// Datapath: seed memory, scan pipeline, nearest tracking, root and divide units.
// Depends on vns_pkg, vns_sqrt and vns_div.
module vns_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  vns_pkg::in_item_t        in_item,
	input  logic                     cfg_we,
	input  logic [vns_pkg::EW_W-1:0] cfg_wdata,
	input  vns_pkg::cmd_t            cmd,
	output vns_pkg::stat_t           stat,
	output vns_pkg::out_item_t       out_item
);

	logic [vns_pkg::ENT_W-1:0]     seed_mem [vns_pkg::SEED_SLOTS];
	logic [vns_pkg::SEED_SLOTS-1:0] active_q;
	logic [vns_pkg::EW_W-1:0]      edge_width_q;
	logic [vns_pkg::X_W-1:0]       px_q;
	logic [vns_pkg::Y_W-1:0]       py_q;

	logic                          v_s1, v_s2;
	logic                          act_s1, act_s2;
	logic [vns_pkg::IDX_W-1:0]     idx_s1, idx_s2;
	logic [vns_pkg::ENT_W-1:0]     rd_s1;
	logic [vns_pkg::DX2_W-1:0]     dx2_s2;
	logic [vns_pkg::DY2_W-1:0]     dy2_s2;
	logic [vns_pkg::R2_W-1:0]      r2_s2;

	logic [vns_pkg::X_W-1:0]       sx, dx;
	logic [vns_pkg::Y_W-1:0]       sy, dy;
	logic [vns_pkg::R_W-1:0]       sr;
	logic [vns_pkg::D_W-1:0]       d;
	logic                          hit;
	logic [vns_pkg::CX_W-1:0]      cx;
	logic [vns_pkg::CY_W-1:0]      cy;

	logic [1:0]                    hits_q;
	logic [vns_pkg::D_W-1:0]       d1_q, d2_q;
	logic [vns_pkg::IDX_W-1:0]     best_q;
	logic                          sel_q;
	logic [vns_pkg::ROOT_W-1:0]    s1_q, s2_q;

	logic                          sq_busy, sq_done;
	logic [vns_pkg::ROOT_W-1:0]    sq_root;
	logic [vns_pkg::RAD_W-1:0]     radicand;
	logic                          dv_busy;
	logic [vns_pkg::NUM_W-1:0]     dv_num, dv_quo;
	logic [vns_pkg::EW_W-1:0]      dv_den;
	logic [vns_pkg::ROOT_W-1:0]    diff;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			edge_width_q <= vns_pkg::EDGE_WIDTH_RESET;
		else if (cfg_we)
			edge_width_q <= cfg_wdata;
	end

	// Seed memory: write on load item, registered read while scanning
	always_ff @(posedge clk) begin
		if (cmd.write && ({1'b0, in_item.seed_index} < (vns_pkg::IDX_W+1)'(vns_pkg::SEED_SLOTS)))
			seed_mem[in_item.seed_index] <= {in_item.seed_x, in_item.seed_y,
				in_item.seed_radius};
		if (cmd.scan_valid)
			rd_s1 <= seed_mem[cmd.scan_addr];
	end

	// Active marks, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			active_q <= '0;
		else if (cmd.write &&
			({1'b0, in_item.seed_index} < (vns_pkg::IDX_W+1)'(vns_pkg::SEED_SLOTS)))
			active_q[in_item.seed_index] <= in_item.seed_active;
	end

	// Latch the query cell, saturated to the grid
	assign cx = (in_item.cell_x > vns_pkg::CX_MAX) ? vns_pkg::CX_MAX : in_item.cell_x;
	assign cy = (in_item.cell_y > vns_pkg::CY_MAX) ? vns_pkg::CY_MAX : in_item.cell_y;

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			px_q <= vns_pkg::X_W'({cx, 8'h00});
			py_q <= vns_pkg::Y_W'({cy, 8'h00});
		end
	end

	// Scan pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_valid;
			v_s2 <= v_s1;
		end
	end

	// Stage one to two: distances and squares
	assign {sx, sy, sr} = rd_s1;
	assign dx = (px_q >= sx) ? px_q - sx : sx - px_q;
	assign dy = (py_q >= sy) ? py_q - sy : sy - py_q;

	always_ff @(posedge clk) begin
		if (cmd.scan_valid) begin
			idx_s1 <= cmd.scan_addr;
			act_s1 <= active_q[cmd.scan_addr];
		end
		if (v_s1) begin
			dx2_s2 <= vns_pkg::DX2_W'(dx) * vns_pkg::DX2_W'(dx);
			dy2_s2 <= vns_pkg::DY2_W'(dy) * vns_pkg::DY2_W'(dy);
			r2_s2  <= vns_pkg::R2_W'(sr) * vns_pkg::R2_W'(sr);
			idx_s2 <= idx_s1;
			act_s2 <= act_s1;
		end
	end

	// Stage two: coverage test and nearest pair update
	assign d   = {1'b0, dx2_s2} + vns_pkg::D_W'(dy2_s2);
	assign hit = act_s2 && ({1'b0, d} <= r2_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hits_q <= '0;
		else if (cmd.start_query)
			hits_q <= '0;
		else if (v_s2 && hit && hits_q != 2'd2)
			hits_q <= hits_q + 2'd1;
	end

	always_ff @(posedge clk) begin
		if (v_s2 && hit) begin
			if (hits_q == 2'd0 || d < d1_q) begin
				d2_q   <= d1_q;
				d1_q   <= d;
				best_q <= idx_s2;
			end else if (hits_q == 2'd1 || d < d2_q) begin
				d2_q <= d;
			end
		end
	end

	// Shared square root over nearest and second distances
	assign radicand = (vns_pkg::RAD_W)'(cmd.sqrt_sel ? d2_q : d1_q);

	vns_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.sqrt_go),
		.radicand (radicand),
		.busy     (sq_busy),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk) begin
		if (cmd.sqrt_go)
			sel_q <= cmd.sqrt_sel;
		if (sq_done) begin
			if (sel_q)
				s2_q <= sq_root;
			else
				s1_q <= sq_root;
		end
	end

	// Edge quotient: rounded diff * 256 / width
	assign diff   = (s2_q >= s1_q) ? s2_q - s1_q : '0;
	assign dv_den = (edge_width_q == '0) ? vns_pkg::EW_W'(1) : edge_width_q;
	assign dv_num = vns_pkg::NUM_W'({diff, 8'h00}) + vns_pkg::NUM_W'(dv_den >> 1);

	vns_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (dv_num),
		.den    (dv_den),
		.busy   (dv_busy),
		.quo    (dv_quo)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (hits_q == 2'd0) begin
				out_item.owner            <= '0;
				out_item.covered          <= 1'b0;
				out_item.nearest_distance <= '1;
				out_item.edge_proximity   <= '0;
			end else begin
				out_item.owner            <= best_q;
				out_item.covered          <= 1'b1;
				out_item.nearest_distance <= s1_q;
				if (hits_q == 2'd2 && dv_quo < vns_pkg::NUM_W'(256))
					out_item.edge_proximity <= 9'd256 - dv_quo[8:0];
				else
					out_item.edge_proximity <= '0;
			end
		end
	end

	assign stat.scan_busy = v_s1 | v_s2;
	assign stat.hits      = hits_q;
	assign stat.sqrt_busy = sq_busy;
	assign stat.div_busy  = dv_busy;

endmodule

>>> hw/rtl/vns_ctrl.sv
// Controller state machine: takes seed writes and sequences scan, roots, divide and result hand-off.
// Depends on vns_pkg and the assertion macro header.
`include "voronoi_nearest_seed_edge_assert.svh"

module vns_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_action,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  vns_pkg::stat_t stat,
	output vns_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SCAN     = 4'd1;
	localparam logic [3:0] S_DRAIN    = 4'd2;
	localparam logic [3:0] S_SQ1_GO   = 4'd3;
	localparam logic [3:0] S_SQ1_WAIT = 4'd4;
	localparam logic [3:0] S_SQ2_GO   = 4'd5;
	localparam logic [3:0] S_SQ2_WAIT = 4'd6;
	localparam logic [3:0] S_DIV_GO   = 4'd7;
	localparam logic [3:0] S_DIV_WAIT = 4'd8;
	localparam logic [3:0] S_OUT      = 4'd9;

	logic [3:0]                state_q, state_n;
	logic [vns_pkg::IDX_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      accept;
	logic                      load;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load     = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Next state and commands
	always_comb begin
		state_n         = state_q;
		cmd             = '0;
		cmd.scan_addr   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_action == vns_pkg::ACT_QUERY) begin
						cmd.start_query = 1'b1;
						state_n         = S_SCAN;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_valid = 1'b1;
				if (cnt_q == vns_pkg::IDX_W'(vns_pkg::SEED_SLOTS - 1))
					state_n = S_DRAIN;
			end
			S_DRAIN: begin
				if (!stat.scan_busy)
					state_n = (stat.hits == 2'd0) ? S_OUT : S_SQ1_GO;
			end
			S_SQ1_GO: begin
				cmd.sqrt_go  = 1'b1;
				cmd.sqrt_sel = 1'b0;
				state_n      = S_SQ1_WAIT;
			end
			S_SQ1_WAIT: begin
				if (!stat.sqrt_busy)
					state_n = (stat.hits == 2'd2) ? S_SQ2_GO : S_OUT;
			end
			S_SQ2_GO: begin
				cmd.sqrt_go  = 1'b1;
				cmd.sqrt_sel = 1'b1;
				state_n      = S_SQ2_WAIT;
			end
			S_SQ2_WAIT: begin
				if (!stat.sqrt_busy)
					state_n = S_DIV_GO;
			end
			S_DIV_GO: begin
				cmd.div_go = 1'b1;
				state_n    = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (!stat.div_busy)
					state_n = S_OUT;
			end
			S_OUT: begin
				if (load) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// State, scan counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.start_query)
				cnt_q <= '0;
			else if (cmd.scan_valid)
				cnt_q <= cnt_q + vns_pkg::IDX_W'(1);
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`VNS_ASSERT_NEXT(a_sqrt_starts, cmd.sqrt_go, stat.sqrt_busy, "root unit did not start")
	`VNS_ASSERT_NEXT(a_div_starts, cmd.div_go, stat.div_busy, "divider did not start")
	`VNS_ASSERT_NEXT(a_load_shows, load, out_valid_q, "loaded result not shown")
	`VNS_ASSERT_NOW(a_no_scan_out, state_q == S_SCAN, !cmd.load_out, "result loaded mid-scan")

endmodule

>>> hw/rtl/voronoi_nearest_seed_edge.sv
// Nearest and second-nearest seed lookup over a 64-entry seed table. A seed load
// item is written when accepted and does not stall the input. A query item scans all
// 64 slots through the seed memory read port, one slot a cycle, then drains the
// two-stage distance pipeline. An uncovered cell then needs no root, a cell with one
// covering seed one 16-step root, and one with two or more seeds two roots and a
// 25-step divide. A result is loaded only once the previous result no longer sits
// stalled in the output register. The input stalls while a query is in progress;
// the result waits in an output register while the next item is accepted.
// Depends on vns_pkg, vns_ctrl and vns_datapath.
module voronoi_nearest_seed_edge (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  vns_pkg::in_item_t        in_item,
	output logic                     out_valid,
	input  logic                     out_stall,
	output vns_pkg::out_item_t       out_item,
	input  logic                     cfg_we,
	input  logic [vns_pkg::EW_W-1:0] cfg_wdata
);

	vns_pkg::cmd_t  cmd;
	vns_pkg::stat_t stat;

	vns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_item.action),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	vns_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_item  (out_item)
	);

endmodule
